// ----- sv/abkf_pkg.sv -----
// Shared types, constants and the step program for the angle/bias Kalman filter.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package abkf_pkg;

  localparam int FRAC_BITS = 22;
  localparam int CFG_W     = 31;

  localparam logic [CFG_W-1:0] RESET_QA = 31'd4194;
  localparam logic [CFG_W-1:0] RESET_QB = 31'd12583;
  localparam logic [CFG_W-1:0] RESET_RM = 31'd125829;
  localparam logic [CFG_W-1:0] RESET_DT = 31'd20972;

  typedef enum logic [1:0] {
    CFG_QA = 2'd0,
    CFG_QB = 2'd1,
    CFG_RM = 2'd2,
    CFG_DT = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    U_ADD,
    U_SUB,
    U_MUL,
    U_RND,
    U_DIV,
    U_END
  } uop_kind_t;

  typedef enum logic [4:0] {
    R_ANGLE,
    R_BIAS,
    R_RATE,
    R_PAA,
    R_PAB,
    R_PBA,
    R_PBB,
    R_TMP,
    R_DP11,
    R_S,
    R_Y,
    R_K0,
    R_K1,
    R_DT,
    R_QA,
    R_QB,
    R_RM,
    R_MANG,
    R_MRATE,
    R_ZERO
  } loc_t;

  typedef struct packed {
    uop_kind_t kind;
    loc_t      dst;
    loc_t      a;
    loc_t      b;
  } uop_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    uop_t uop;
    logic div_start;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  localparam logic [5:0] PC_STEP = 6'd0;
  localparam logic [5:0] PC_SET  = 6'd39;

  // Step program. A multiply leaves its product in a register; the following
  // round operation writes the rounded, saturated value to its destination.
  function automatic uop_t ucode(input logic [5:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = '{U_SUB, R_RATE,  R_MRATE, R_BIAS};
      6'd1:  u = '{U_MUL, R_ZERO,  R_DT,    R_RATE};
      6'd2:  u = '{U_RND, R_TMP,   R_ZERO,  R_ZERO};
      6'd3:  u = '{U_ADD, R_ANGLE, R_ANGLE, R_TMP};
      6'd4:  u = '{U_MUL, R_ZERO,  R_DT,    R_PBB};
      6'd5:  u = '{U_RND, R_DP11,  R_ZERO,  R_ZERO};
      6'd6:  u = '{U_SUB, R_TMP,   R_DP11,  R_PAB};
      6'd7:  u = '{U_SUB, R_TMP,   R_TMP,   R_PBA};
      6'd8:  u = '{U_ADD, R_TMP,   R_TMP,   R_QA};
      6'd9:  u = '{U_MUL, R_ZERO,  R_DT,    R_TMP};
      6'd10: u = '{U_RND, R_TMP,   R_ZERO,  R_ZERO};
      6'd11: u = '{U_ADD, R_PAA,   R_PAA,   R_TMP};
      6'd12: u = '{U_SUB, R_PAB,   R_PAB,   R_DP11};
      6'd13: u = '{U_SUB, R_PBA,   R_PBA,   R_DP11};
      6'd14: u = '{U_MUL, R_ZERO,  R_QB,    R_DT};
      6'd15: u = '{U_RND, R_TMP,   R_ZERO,  R_ZERO};
      6'd16: u = '{U_ADD, R_PBB,   R_PBB,   R_TMP};
      6'd17: u = '{U_ADD, R_S,     R_PAA,   R_RM};
      6'd18: u = '{U_DIV, R_ZERO,  R_ZERO,  R_ZERO};
      6'd19: u = '{U_SUB, R_Y,     R_MANG,  R_ANGLE};
      6'd20: u = '{U_MUL, R_ZERO,  R_K0,    R_Y};
      6'd21: u = '{U_RND, R_TMP,   R_ZERO,  R_ZERO};
      6'd22: u = '{U_ADD, R_ANGLE, R_ANGLE, R_TMP};
      6'd23: u = '{U_MUL, R_ZERO,  R_K1,    R_Y};
      6'd24: u = '{U_RND, R_TMP,   R_ZERO,  R_ZERO};
      6'd25: u = '{U_ADD, R_BIAS,  R_BIAS,  R_TMP};
      // The covariance corrections all use the pre-update P00 and P01,
      // so the four products are parked in free temporaries first.
      6'd26: u = '{U_MUL, R_ZERO,  R_K0,    R_PAA};
      6'd27: u = '{U_RND, R_DP11,  R_ZERO,  R_ZERO};
      6'd28: u = '{U_MUL, R_ZERO,  R_K0,    R_PAB};
      6'd29: u = '{U_RND, R_S,     R_ZERO,  R_ZERO};
      6'd30: u = '{U_MUL, R_ZERO,  R_K1,    R_PAA};
      6'd31: u = '{U_RND, R_Y,     R_ZERO,  R_ZERO};
      6'd32: u = '{U_MUL, R_ZERO,  R_K1,    R_PAB};
      6'd33: u = '{U_RND, R_TMP,   R_ZERO,  R_ZERO};
      6'd34: u = '{U_SUB, R_PAA,   R_PAA,   R_DP11};
      6'd35: u = '{U_SUB, R_PAB,   R_PAB,   R_S};
      6'd36: u = '{U_SUB, R_PBA,   R_PBA,   R_Y};
      6'd37: u = '{U_SUB, R_PBB,   R_PBB,   R_TMP};
      6'd38: u = '{U_END, R_ZERO,  R_ZERO,  R_ZERO};
      6'd39: u = '{U_ADD, R_ANGLE, R_MANG,  R_ZERO};
      default: u = '{U_END, R_ZERO, R_ZERO, R_ZERO};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

// ----- sv/abkf_div.sv -----
// Two-lane restoring divider for the Kalman gains, sharing one divisor.
// Depends on abkf_pkg for the fraction width.
`default_nettype none
module abkf_div #(
  parameter int W = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic signed [W-1:0] num0,
  input  wire logic signed [W-1:0] num1,
  input  wire logic signed [W-1:0] den,
  output logic                     done,
  output logic signed [W-1:0]      quo0,
  output logic signed [W-1:0]      quo1
);
  import abkf_pkg::*;

  localparam int N  = W + FRAC_BITS;
  localparam int CW = $clog2(N + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic          zero_d;
  logic [W-1:0]  dmag;

  logic [W-1:0]          nmag  [2];
  logic                  nsign [2];
  logic [N-1:0]          sh    [2];
  logic [W-1:0]          rem   [2];
  logic                  neg   [2];
  logic signed [W-1:0]   res   [2];

  assign nmag[0]  = num0[W-1] ? (~num0 + W'(1)) : num0;
  assign nmag[1]  = num1[W-1] ? (~num1 + W'(1)) : num1;
  assign nsign[0] = num0[W-1] ^ den[W-1];
  assign nsign[1] = num1[W-1] ^ den[W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero_d <= (den == '0);
      dmag   <= den[W-1] ? (~den + W'(1)) : den;
    end
  end

  for (genvar i = 0; i < 2; i++) begin : g_lane
    logic [W:0] trial;
    logic       ge;
    logic       big;

    assign trial = {rem[i], sh[i][N-1]};
    assign ge    = (trial >= {1'b0, dmag});
    assign big   = |sh[i][N-1:W-1];

    always_ff @(posedge clk) begin
      if (start) begin
        sh[i]  <= {nmag[i], {FRAC_BITS{1'b0}}};
        rem[i] <= '0;
        neg[i] <= nsign[i];
      end else if (busy) begin
        rem[i] <= ge ? W'(trial - {1'b0, dmag}) : trial[W-1:0];
        sh[i]  <= {sh[i][N-2:0], ge};
      end
    end

    always_comb begin
      if (zero_d) begin
        res[i] = '0;
      end else if (big) begin
        res[i] = neg[i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        res[i] = neg[i] ? (~sh[i][W-1:0] + W'(1)) : sh[i][W-1:0];
      end
    end
  end

  assign quo0 = res[0];
  assign quo1 = res[1];

endmodule
`default_nettype wire

// ----- sv/abkf_datapath.sv -----
// Datapath: filter state, configuration registers, saturating adder,
// shared multiplier with rounding, and the gain divider.
// Depends on abkf_pkg and abkf_div.
`default_nettype none
module abkf_datapath #(
  parameter int W = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire abkf_pkg::dp_cmd_t       cmd,
  output abkf_pkg::dp_stat_t           stat,
  input  wire logic                    cfg_write,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [30:0]             cfg_data,
  input  wire logic signed [31:0]      measured_angle,
  input  wire logic signed [31:0]      measured_rate,
  output logic signed [31:0]           angle_estimate,
  output logic signed [31:0]           unbiased_rate
);
  import abkf_pkg::*;

  localparam logic signed [63:0] POS64 = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] NEG64 = -POS64 - 64'sd1;
  localparam logic [W-1:0]       MAXW  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]       MINW  = {1'b1, {(W-1){1'b0}}};

  logic [CFG_W-1:0] qa_cfg, qb_cfg, rm_cfg, dt_cfg;
  logic signed [W-1:0] angle, bias, rate, paa, pab, pba, pbb;
  logic signed [W-1:0] tmp, dp11, s, y, k0, k1, m_ang, m_rate;
  logic [2*W-1:0]      prod;
  logic                pneg;

  function automatic logic [W-1:0] sat_cfg(input logic [CFG_W-1:0] v);
    logic [63:0] e;
    e = {33'd0, v};
    return (e > 64'(POS64)) ? MAXW : e[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_in(input logic [31:0] v);
    logic signed [63:0] e;
    e = {{32{v[31]}}, v};
    if (e > POS64) return MAXW;
    if (e < NEG64) return MINW;
    return e[W-1:0];
  endfunction

  function automatic logic [31:0] low32(input logic [W-1:0] v);
    logic [63:0] e;
    e = {{(64-W){v[W-1]}}, v};
    return e[31:0];
  endfunction

  function automatic logic [W-1:0] pick(input loc_t sel, input logic [W-1:0] a0,
      input logic [W-1:0] a1, input logic [W-1:0] a2, input logic [W-1:0] a3,
      input logic [W-1:0] a4, input logic [W-1:0] a5, input logic [W-1:0] a6,
      input logic [W-1:0] a7, input logic [W-1:0] a8, input logic [W-1:0] a9,
      input logic [W-1:0] a10, input logic [W-1:0] a11, input logic [W-1:0] a12,
      input logic [W-1:0] a13, input logic [W-1:0] a14, input logic [W-1:0] a15,
      input logic [W-1:0] a16, input logic [W-1:0] a17, input logic [W-1:0] a18);
    logic [W-1:0] r;
    case (sel)
      R_ANGLE: r = a0;
      R_BIAS:  r = a1;
      R_RATE:  r = a2;
      R_PAA:   r = a3;
      R_PAB:   r = a4;
      R_PBA:   r = a5;
      R_PBB:   r = a6;
      R_TMP:   r = a7;
      R_DP11:  r = a8;
      R_S:     r = a9;
      R_Y:     r = a10;
      R_K0:    r = a11;
      R_K1:    r = a12;
      R_DT:    r = a13;
      R_QA:    r = a14;
      R_QB:    r = a15;
      R_RM:    r = a16;
      R_MANG:  r = a17;
      R_MRATE: r = a18;
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [W-1:0] opa, opb, ma, mb, alu_res, rnd_res, wr_val;
  logic [W:0]   sum;
  logic [2*W:0] rsum;
  logic [2*W-FRAC_BITS:0] qv;
  logic         big;
  logic         div_done;
  logic signed [W-1:0] quo0, quo1;

  always_comb begin
    opa = pick(cmd.uop.a, angle, bias, rate, paa, pab, pba, pbb, tmp, dp11, s, y,
               k0, k1, sat_cfg(dt_cfg), sat_cfg(qa_cfg), sat_cfg(qb_cfg),
               sat_cfg(rm_cfg), m_ang, m_rate);
    opb = pick(cmd.uop.b, angle, bias, rate, paa, pab, pba, pbb, tmp, dp11, s, y,
               k0, k1, sat_cfg(dt_cfg), sat_cfg(qa_cfg), sat_cfg(qb_cfg),
               sat_cfg(rm_cfg), m_ang, m_rate);
  end

  // Saturating add or subtract.
  always_comb begin
    if (cmd.uop.kind == U_SUB) begin
      sum = {opa[W-1], opa} - {opb[W-1], opb};
    end else begin
      sum = {opa[W-1], opa} + {opb[W-1], opb};
    end
    if (sum[W] != sum[W-1]) begin
      alu_res = sum[W] ? MINW : MAXW;
    end else begin
      alu_res = sum[W-1:0];
    end
  end

  assign ma = opa[W-1] ? (~opa + W'(1)) : opa;
  assign mb = opb[W-1] ? (~opb + W'(1)) : opb;

  // Round the stored magnitude product to nearest, ties away from zero.
  assign rsum = {1'b0, prod} + ((2*W+1)'(1) << (FRAC_BITS - 1));
  assign qv   = rsum[2*W:FRAC_BITS];
  assign big  = |qv[2*W-FRAC_BITS:W-1];

  always_comb begin
    if (big) begin
      rnd_res = pneg ? MINW : MAXW;
    end else begin
      rnd_res = pneg ? (~qv[W-1:0] + W'(1)) : qv[W-1:0];
    end
  end

  assign wr_val = (cmd.uop.kind == U_RND) ? rnd_res : alu_res;

  always_ff @(posedge clk) begin
    if (cmd.exec && cmd.uop.kind == U_MUL) begin
      prod <= {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
      pneg <= opa[W-1] ^ opb[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      bias  <= '0;
      rate  <= '0;
      paa   <= '0;
      pab   <= '0;
      pba   <= '0;
      pbb   <= '0;
    end else if (cmd.exec && (cmd.uop.kind == U_ADD || cmd.uop.kind == U_SUB ||
                              cmd.uop.kind == U_RND)) begin
      case (cmd.uop.dst)
        R_ANGLE: angle <= wr_val;
        R_BIAS:  bias  <= wr_val;
        R_RATE:  rate  <= wr_val;
        R_PAA:   paa   <= wr_val;
        R_PAB:   pab   <= wr_val;
        R_PBA:   pba   <= wr_val;
        R_PBB:   pbb   <= wr_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (cmd.uop.kind == U_ADD || cmd.uop.kind == U_SUB ||
                     cmd.uop.kind == U_RND)) begin
      case (cmd.uop.dst)
        R_TMP:   tmp  <= wr_val;
        R_DP11:  dp11 <= wr_val;
        R_S:     s    <= wr_val;
        R_Y:     y    <= wr_val;
        default: ;
      endcase
    end
    if (div_done) begin
      k0 <= quo0;
      k1 <= quo1;
    end
    if (cmd.load_in) begin
      m_ang  <= sat_in(measured_angle);
      m_rate <= sat_in(measured_rate);
    end
    if (cmd.load_out) begin
      angle_estimate <= low32(angle);
      unbiased_rate  <= low32(rate);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qa_cfg <= RESET_QA;
      qb_cfg <= RESET_QB;
      rm_cfg <= RESET_RM;
      dt_cfg <= RESET_DT;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_QA:  qa_cfg <= cfg_data;
        CFG_QB:  qb_cfg <= cfg_data;
        CFG_RM:  rm_cfg <= cfg_data;
        CFG_DT:  dt_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  abkf_div #(.W(W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num0  (paa),
    .num1  (pba),
    .den   (s),
    .done  (div_done),
    .quo0  (quo0),
    .quo1  (quo1)
  );

  assign stat.div_done = div_done;

endmodule
`default_nettype wire

// ----- sv/abkf_ctrl.sv -----
// Controller: sequences the step program over the datapath and runs the
// input and output handshakes. Depends on abkf_pkg.
`default_nettype none
module abkf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                op,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output abkf_pkg::dp_cmd_t        cmd,
  input  wire abkf_pkg::dp_stat_t  stat
);
  import abkf_pkg::*;

  state_t     state, state_next;
  logic [5:0] pc, pc_next;
  uop_t       uop;
  logic       out_free;

  assign uop      = ucode(pc);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    pc_next    = pc;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_RUN;
          pc_next    = op ? PC_SET : PC_STEP;
        end
      end
      S_RUN: begin
        case (uop.kind)
          U_END: state_next = S_OUT;
          U_DIV: begin
            state_next = S_DIV;
            pc_next    = pc + 6'd1;
          end
          default: pc_next = pc + 6'd1;
        endcase
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_RUN;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.uop       = uop;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_RUN: begin
        cmd.exec      = (uop.kind != U_END) && (uop.kind != U_DIV);
        cmd.div_start = (uop.kind == U_DIV);
      end
      S_OUT: cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= PC_STEP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/angle_bias_kalman_filter_unit.sv -----
// Top level of the two-state angle and gyro-bias Kalman filter.
// Depends on abkf_pkg, abkf_ctrl and abkf_datapath.
//
// Usage: an input item (op, measured_angle, measured_rate) is taken on
// in_valid and in_ready; each item yields exactly one result item
// (angle_estimate, unbiased_rate) on out_valid and out_ready.
// Configuration registers are written with cfg_write, cfg_index and
// cfg_data; the user must write them only while the block is idle, as
// the block itself does not enforce it. Index 0 is the angle process
// noise, 1 the bias process noise, 2 the measurement noise and 3 the
// time step. A filter step runs a 38-operation program on one shared
// multiplier and adder, one operation being the gain division on a
// restoring divider. One item is in work at a time; in_ready rises
// again once the result has been placed in the output register, so a
// new item can be taken while that result still waits. If the receiver
// stalls, the next finished result waits in the filter state, with the
// controller holding, until the output register is free. Reset clears the
// filter state, restores the register defaults and empties the output.
`default_nettype none
module angle_bias_kalman_filter_unit #(
  parameter int WORD_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               op,
  input  wire logic signed [31:0] measured_angle,
  input  wire logic signed [31:0] measured_rate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      angle_estimate,
  output logic signed [31:0]      unbiased_rate,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_data
);
  import abkf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  abkf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  abkf_datapath #(.W(WORD_WIDTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .measured_angle (measured_angle),
    .measured_rate  (measured_rate),
    .angle_estimate (angle_estimate),
    .unbiased_rate  (unbiased_rate)
  );

endmodule
`default_nettype wire
